[design/qvr_pkg.sv]
// Shared types and constants for the quaternion vector rotation block.
// No dependencies; imported by qvr_row and quaternion_vector_rotate.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

  localparam int COORD_W   = 24;
  localparam int QUAT_FRAC = 16;
  localparam int QUAT_W    = QUAT_FRAC + 2;
  localparam int SQ_W      = 2 * QUAT_W;          // quaternion product
  localparam int TERM_W    = SQ_W + 2;            // matrix term, includes the x2
  localparam int PROD_W    = TERM_W + COORD_W;    // term * coordinate
  localparam int ACC_W     = PROD_W + 2;          // sum of three plus rounding
  localparam int SHIFT     = 2 * QUAT_FRAC;
  localparam int RND_W     = ACC_W - SHIFT;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 4;

  localparam logic [ACC_W-1:0] RND_HALF =
    {{(ACC_W-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [QUAT_W-1:0]  QUAT_ONE  =
    {{(QUAT_W-QUAT_FRAC-1){1'b0}}, 1'b1, {QUAT_FRAC{1'b0}}};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [SQ_W-1:0]    sq_t;
  typedef logic signed [TERM_W-1:0]  term_t;

  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } qvr_reg_t;

  // load enables of the row stages
  typedef struct packed {
    logic en3;
    logic en4;
    logic en5;
  } qvr_adv_t;

endpackage

`default_nettype wire

[design/qvr_row.sv]
// One output row: three term*coordinate products, rounded sum, saturation.
// Depends on qvr_pkg; instantiated three times by quaternion_vector_rotate.
`timescale 1ns / 1ps
`default_nettype none

module qvr_row (
  input  wire logic              clk,
  input  wire qvr_pkg::qvr_adv_t adv,
  input  wire qvr_pkg::term_t    m0,
  input  wire qvr_pkg::term_t    m1,
  input  wire qvr_pkg::term_t    m2,
  input  wire qvr_pkg::coord_t   vx,
  input  wire qvr_pkg::coord_t   vy,
  input  wire qvr_pkg::coord_t   vz,
  output qvr_pkg::coord_t        coord,
  output logic                   sat
);
  import qvr_pkg::*;

  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic signed [ACC_W-1:0]  sum;
  logic signed [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [RND_W-COORD_W:0]   upper;
  logic                     ovf;
  coord_t                   coord_r, coord_nxt;
  logic                     sat_r, sat_nxt;

  // stage 3: products
  always_comb begin
    p0_nxt = m0 * vx;
    p1_nxt = m1 * vy;
    p2_nxt = m2 * vz;
  end

  // stage 4: exact sum, add half LSB, floor
  always_comb begin
    sum     = ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(p2_r) + $signed(RND_HALF);
    rnd_nxt = RND_W'(sum >>> SHIFT);
  end

  // stage 5: clip to coordinate range
  always_comb begin
    upper = rnd_r[RND_W-1:COORD_W-1];
    ovf   = !((&upper) || !(|upper));
    if (ovf) begin
      coord_nxt = rnd_r[RND_W-1] ? COORD_MIN : COORD_MAX;
    end else begin
      coord_nxt = rnd_r[COORD_W-1:0];
    end
    sat_nxt = ovf;
  end

  always_ff @(posedge clk) begin
    if (adv.en3) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (adv.en4) begin
      rnd_r <= rnd_nxt;
    end
    if (adv.en5) begin
      coord_r <= coord_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign coord = coord_r;
  assign sat   = sat_r;

endmodule

`default_nettype wire

[design/quaternion_vector_rotate.sv]
// Top level of the quaternion vector rotation block: config registers,
// quaternion products, matrix terms and the valid/stall pipeline control.
// Depends on qvr_pkg and qvr_row.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | ports                                     | dir | notes
//  ---------+-------------------------------------------+-----+---------------------------
//  input    | in_valid, in_stall, in_vec_x/y/z          | in  | one point per request
//  result   | out_valid, out_stall, out_x/y/z,          | out | one rotated point per
//           | out_saturated                             |     | request, in order
//  config   | psel, penable, pwrite, paddr, pwdata,     | in  | quat_w/x/y/z at 0x0/4/8/C
//           | prdata, pready                            |     | Q2.16, read back sign-ext
//
//  Throughput is one request per cycle unless the output stalls. From acceptance to
//  out_valid a request passes products, terms, row products, rounded sum, saturate/output reg.
//  Each stage holds only while the stage after it is full and cannot move, so
//  bubbles are squeezed out and a stalled output does not block input until the
//  pipe is full. Reset clears all valid bits and loads the identity quaternion.
//  The quaternion is sampled by each request as it enters stage 1.

module quaternion_vector_rotate (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire qvr_pkg::coord_t             in_vec_x,
  input  wire qvr_pkg::coord_t             in_vec_y,
  input  wire qvr_pkg::coord_t             in_vec_z,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output qvr_pkg::coord_t                  out_x,
  output qvr_pkg::coord_t                  out_y,
  output qvr_pkg::coord_t                  out_z,
  output logic                             out_saturated,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [qvr_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [qvr_pkg::CFG_DW-1:0]  pwdata,
  output logic [qvr_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready
);
  import qvr_pkg::*;

  // ---------------- configuration registers ----------------
  quat_t    qw_r, qx_r, qy_r, qz_r;
  qvr_reg_t wr_sel, rd_sel;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign wr_sel = qvr_reg_t'(paddr[3:2]);
  assign rd_sel = qvr_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r <= QUAT_ONE;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else if (cfg_wr) begin
      unique case (wr_sel)
        REG_QUAT_W: qw_r <= pwdata[QUAT_W-1:0];
        REG_QUAT_X: qx_r <= pwdata[QUAT_W-1:0];
        REG_QUAT_Y: qy_r <= pwdata[QUAT_W-1:0];
        REG_QUAT_Z: qz_r <= pwdata[QUAT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (rd_sel)
      REG_QUAT_W: prdata = CFG_DW'(qw_r);
      REG_QUAT_X: prdata = CFG_DW'(qx_r);
      REG_QUAT_Y: prdata = CFG_DW'(qy_r);
      REG_QUAT_Z: prdata = CFG_DW'(qz_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // a stage loads when it is empty or its content moves on
  logic     v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic     rdy1, rdy2, rdy3, rdy4, rdy5;
  qvr_adv_t adv;

  assign rdy5 = !out_valid_r || !out_stall;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_stall = !rdy1;
  assign adv      = '{en3: rdy3, en4: rdy4, en5: rdy5};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_valid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) v4_r        <= v3_r;
      if (rdy5) out_valid_r <= v4_r;
    end
  end

  // ---------------- stage 1: quaternion products ----------------
  sq_t    aa_r, bb_r, cc_r, dd_r, ab_r, ac_r, ad_r, bc_r, bd_r, cd_r;
  coord_t vx1_r, vy1_r, vz1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      aa_r  <= qw_r * qw_r;
      bb_r  <= qx_r * qx_r;
      cc_r  <= qy_r * qy_r;
      dd_r  <= qz_r * qz_r;
      ab_r  <= qw_r * qx_r;
      ac_r  <= qw_r * qy_r;
      ad_r  <= qw_r * qz_r;
      bc_r  <= qx_r * qy_r;
      bd_r  <= qx_r * qz_r;
      cd_r  <= qy_r * qz_r;
      vx1_r <= in_vec_x;
      vy1_r <= in_vec_y;
      vz1_r <= in_vec_z;
    end
  end

  // ---------------- stage 2: rotation matrix terms ----------------
  term_t  m11_nxt, m12_nxt, m13_nxt, m21_nxt, m22_nxt, m23_nxt;
  term_t  m31_nxt, m32_nxt, m33_nxt;
  term_t  t12, t13, t21, t23, t31, t32;
  term_t  m11_r, m12_r, m13_r, m21_r, m22_r, m23_r, m31_r, m32_r, m33_r;
  coord_t vx2_r, vy2_r, vz2_r;

  always_comb begin
    m11_nxt = TERM_W'(aa_r) + TERM_W'(bb_r) - TERM_W'(cc_r) - TERM_W'(dd_r);
    m22_nxt = TERM_W'(aa_r) - TERM_W'(bb_r) + TERM_W'(cc_r) - TERM_W'(dd_r);
    m33_nxt = TERM_W'(aa_r) - TERM_W'(bb_r) - TERM_W'(cc_r) + TERM_W'(dd_r);
    t12     = TERM_W'(bc_r) - TERM_W'(ad_r);
    t13     = TERM_W'(bd_r) + TERM_W'(ac_r);
    t21     = TERM_W'(bc_r) + TERM_W'(ad_r);
    t23     = TERM_W'(cd_r) - TERM_W'(ab_r);
    t31     = TERM_W'(bd_r) - TERM_W'(ac_r);
    t32     = TERM_W'(cd_r) + TERM_W'(ab_r);
    m12_nxt = t12 + t12;
    m13_nxt = t13 + t13;
    m21_nxt = t21 + t21;
    m23_nxt = t23 + t23;
    m31_nxt = t31 + t31;
    m32_nxt = t32 + t32;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      m11_r <= m11_nxt;
      m12_r <= m12_nxt;
      m13_r <= m13_nxt;
      m21_r <= m21_nxt;
      m22_r <= m22_nxt;
      m23_r <= m23_nxt;
      m31_r <= m31_nxt;
      m32_r <= m32_nxt;
      m33_r <= m33_nxt;
      vx2_r <= vx1_r;
      vy2_r <= vy1_r;
      vz2_r <= vz1_r;
    end
  end

  // ---------------- stages 3..5: one unit per output row ----------------
  logic sat_x, sat_y, sat_z;

  qvr_row u_row_x (
    .clk   (clk),
    .adv   (adv),
    .m0    (m11_r),
    .m1    (m12_r),
    .m2    (m13_r),
    .vx    (vx2_r),
    .vy    (vy2_r),
    .vz    (vz2_r),
    .coord (out_x),
    .sat   (sat_x)
  );

  qvr_row u_row_y (
    .clk   (clk),
    .adv   (adv),
    .m0    (m21_r),
    .m1    (m22_r),
    .m2    (m23_r),
    .vx    (vx2_r),
    .vy    (vy2_r),
    .vz    (vz2_r),
    .coord (out_y),
    .sat   (sat_y)
  );

  qvr_row u_row_z (
    .clk   (clk),
    .adv   (adv),
    .m0    (m31_r),
    .m1    (m32_r),
    .m2    (m33_r),
    .vx    (vx2_r),
    .vy    (vy2_r),
    .vz    (vz2_r),
    .coord (out_z),
    .sat   (sat_z)
  );

  assign out_valid     = out_valid_r;
  assign out_saturated = sat_x | sat_y | sat_z;

endmodule

`default_nettype wire

[tb/qvr_rotation_checker.sv]
// Checker for quaternion_vector_rotate: tracks the quaternion registers,
// predicts each rotated point and compares it with the result channel.
// Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_rotation_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire qvr_pkg::coord_t            in_vec_x,
  input  wire qvr_pkg::coord_t            in_vec_y,
  input  wire qvr_pkg::coord_t            in_vec_z,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire qvr_pkg::coord_t            out_x,
  input  wire qvr_pkg::coord_t            out_y,
  input  wire qvr_pkg::coord_t            out_z,
  input  wire logic                       out_saturated,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic                       pready,
  input  wire logic [qvr_pkg::CFG_AW-1:0] paddr,
  input  wire logic [qvr_pkg::CFG_DW-1:0] pwdata,
  output int unsigned                     fail_count,
  output int unsigned                     pending
);
  import qvr_pkg::*;

  // wide enough for any sum of three term*coordinate products
  typedef logic signed [95:0] wide_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } rotated_t;

  rotated_t expected_points [$];
  quat_t    rot_w, rot_x, rot_y, rot_z;

  function automatic rotated_t rotate_point(quat_t qw, quat_t qx, quat_t qy, quat_t qz,
                                            coord_t px, coord_t py, coord_t pz);
    wide_t    a, b, c, d, row_sum, hi_lim, lo_lim;
    wide_t    m [3][3];
    wide_t    v [3];
    coord_t   comp [3];
    rotated_t res;
    a = qw;
    b = qx;
    c = qy;
    d = qz;
    v[0] = px;
    v[1] = py;
    v[2] = pz;
    m[0][0] = a*a + b*b - c*c - d*d;
    m[0][1] = 2 * (b*c - a*d);
    m[0][2] = 2 * (b*d + a*c);
    m[1][0] = 2 * (b*c + a*d);
    m[1][1] = a*a - b*b + c*c - d*d;
    m[1][2] = 2 * (c*d - a*b);
    m[2][0] = 2 * (b*d - a*c);
    m[2][1] = 2 * (c*d + a*b);
    m[2][2] = a*a - b*b - c*c + d*d;
    hi_lim = (wide_t'(1) <<< (COORD_W - 1)) - 1;
    lo_lim = -hi_lim - 1;
    res.sat = 1'b0;
    for (int r = 0; r < 3; r++) begin
      // round half up: add half an output LSB, then floor
      row_sum = m[r][0]*v[0] + m[r][1]*v[1] + m[r][2]*v[2] + (wide_t'(1) <<< (SHIFT - 1));
      row_sum = row_sum >>> SHIFT;
      if (row_sum > hi_lim) begin
        row_sum = hi_lim;
        res.sat = 1'b1;
      end else if (row_sum < lo_lim) begin
        row_sum = lo_lim;
        res.sat = 1'b1;
      end
      comp[r] = row_sum[COORD_W-1:0];
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    rotated_t want;
    if (!rst_n) begin
      expected_points.delete();
      rot_w = QUAT_ONE;
      rot_x = '0;
      rot_y = '0;
      rot_z = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected point x=%0d y=%0d z=%0d sat=%0b", $realtime,
                     out_x, out_y, out_z, out_saturated);
        end else begin
          want = expected_points.pop_front();
          if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
              out_saturated !== want.sat) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
                       $realtime, want.x, want.y, want.z, want.sat,
                       out_x, out_y, out_z, out_saturated);
          end
        end
      end
      // quaternion is taken as the request is accepted
      if (in_valid && !in_stall)
        expected_points.push_back(rotate_point(rot_w, rot_x, rot_y, rot_z,
                                               in_vec_x, in_vec_y, in_vec_z));
      if (psel && penable && pwrite && pready) begin
        case (qvr_reg_t'(paddr[3:2]))
          REG_QUAT_W: rot_w = pwdata[QUAT_W-1:0];
          REG_QUAT_X: rot_x = pwdata[QUAT_W-1:0];
          REG_QUAT_Y: rot_y = pwdata[QUAT_W-1:0];
          REG_QUAT_Z: rot_z = pwdata[QUAT_W-1:0];
        endcase
      end
    end
    pending = expected_points.size();
  end

endmodule

[tb/quaternion_vector_rotate_tb.sv]
// Top of the quaternion_vector_rotate testbench: clock, reset, request and
// register stimulus, receiver stalls and the verdict.
// Depends on qvr_pkg, quaternion_vector_rotate and qvr_rotation_checker.
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;
  import qvr_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  localparam coord_t C_MAX  = COORD_MAX;
  localparam coord_t C_MIN  = COORD_MIN;
  localparam quat_t  Q_MAX  = {1'b0, {(QUAT_W-1){1'b1}}};
  localparam quat_t  Q_MIN  = {1'b1, {(QUAT_W-1){1'b0}}};
  localparam quat_t  Q_ONE  = QUAT_ONE;
  localparam quat_t  Q_HALF = QUAT_ONE >> 1;
  localparam quat_t  Q_C45  = 46341;     // cos(45 deg) in Q2.16

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  coord_t            in_vec_x, in_vec_y, in_vec_z;
  logic              out_valid;
  logic              out_stall;
  coord_t            out_x, out_y, out_z;
  logic              out_saturated;
  logic              psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // idling knobs, percent per cycle; hold_left forces a long receiver stall
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int hold_left    = 0;

  always #10 clk = ~clk;

  quaternion_vector_rotate dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_saturated (out_saturated),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  qvr_rotation_checker rotation_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_saturated (out_saturated),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** quaternion_vector_rotate: FAILED **");
      $finish;
    end
  end

  // Receiver. A pending hold stalls the output solidly and is counted down
  // here; otherwise stall at random with the current percentage.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one request and hold it until taken. The stall read just after the
  // edge is the value the block saw at that edge. Afterwards the sender may
  // go idle for a few cycles; with no gap the next call keeps valid high.
  task automatic send_point(input coord_t px, input coord_t py, input coord_t pz);
    in_vec_x <= px;
    in_vec_y <= py;
    in_vec_z <= pz;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      in_vec_x <= coord_t'($urandom);    // payload is don't-care while idle
      @(posedge clk);
    end
  endtask

  // Mix of full-range, small, mid-size and extreme coordinates.
  function automatic coord_t random_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(8191)) - 4096);
      2: return coord_t'(int'($urandom_range(1 << 17)) - (1 << 16));
      default: begin
        case ($urandom_range(3))
          0: return C_MAX;
          1: return C_MIN;
          2: return coord_t'(0);
          default: return coord_t'(-1);
        endcase
      end
    endcase
  endfunction

  task automatic send_random_point();
    send_point(random_coord(), random_coord(), random_coord());
  endtask

  // Stop offering and wait until every predicted point has come back, then
  // let the pipe settle a little longer.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  // Bits above the register width carry junk; the block must drop them.
  task automatic write_reg(input qvr_reg_t idx, input quat_t val);
    logic [CFG_DW-1:0] word;
    word = $urandom;
    word[QUAT_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // New rotation only with the block empty.
  task automatic set_rotation(input quat_t qw, input quat_t qx, input quat_t qy,
                              input quat_t qz);
    drain();
    write_reg(REG_QUAT_W, qw);
    write_reg(REG_QUAT_X, qx);
    write_reg(REG_QUAT_Y, qy);
    write_reg(REG_QUAT_Z, qz);
  endtask

  initial begin
    real   r [4];
    real   norm;
    quat_t q [4];
    int    gap_modes   [4] = '{0, 49, 0, 27};
    int    stall_modes [4] = '{0, 0, 49, 27};

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_vec_x  = '0;
    in_vec_y  = '0;
    in_vec_z  = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed requests ---
    // reset quaternion is identity: points pass through, extremes included
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(0, 0, 0);
    send_point(-1, 1, -256);
    send_point(256, C_MIN, C_MAX);

    // 90 degrees about z: x goes to y, inexact terms exercise rounding
    set_rotation(Q_C45, 0, 0, Q_C45);
    send_point(256, 0, 0);
    send_point(C_MAX, 0, 0);
    send_point(C_MIN, C_MAX, 1);
    send_point(-1, -1, -1);

    // w = 0.5 alone scales by 1/4: exact half-LSB ties, both signs
    set_rotation(Q_HALF, 0, 0, 0);
    send_point(2, -2, 6);
    send_point(-6, 1, 3);
    send_point(C_MAX, C_MIN, -1);
    send_point(1, -1, 5);

    // unnormalized, every part at its maximum: heavy gain, saturation
    set_rotation(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(1, 0, 0);
    send_point(1000, -1000, 12345);

    // every part at its minimum
    set_rotation(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_point(C_MAX, 0, 0);
    send_point(C_MIN, 1, -1);
    send_point(65536, -65536, 256);

    // zero quaternion maps everything to the origin
    set_rotation(0, 0, 0, 0);
    send_point(C_MAX, C_MIN, C_MAX);
    send_point(123, 456, -789);

    // mixed extremes
    set_rotation(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_point(C_MAX, C_MAX, C_MIN);
    send_point(300, -300, 0);

    // --- random phases, each under its own quaternion and idling mode ---
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin
          // unit quaternion from a random direction
          norm = 0.0;
          for (int i = 0; i < 4; i++) begin
            r[i] = real'(int'($urandom_range(2000)) - 1000);
            norm += r[i] * r[i];
          end
          norm = $sqrt(norm);
          for (int i = 0; i < 4; i++)
            q[i] = (norm > 0.0) ? quat_t'($rtoi(r[i] / norm * 65535.0)) : quat_t'(0);
        end
        1: for (int i = 0; i < 4; i++) q[i] = quat_t'($urandom);
        2: for (int i = 0; i < 4; i++) q[i] = quat_t'(int'($urandom_range(65536)) - 32768);
        default: begin
          for (int i = 0; i < 4; i++) begin
            case ($urandom_range(3))
              0: q[i] = Q_MAX;
              1: q[i] = Q_MIN;
              2: q[i] = Q_ONE;
              default: q[i] = 0;
            endcase
          end
        end
      endcase
      set_rotation(q[0], q[1], q[2], q[3]);
      send_gap_pct = gap_modes[phase % 4];
      stall_pct    = stall_modes[phase % 4];
      repeat (28) send_random_point();
    end

    // --- back-pressure: receiver holds off long enough that the pipe fills
    // and in_stall rises, while the sender keeps offering every cycle ---
    set_rotation(Q_C45, Q_C45, 0, 0);
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_left    = 80;
    repeat (40) send_random_point();

    drain();
    if (fail_count == 0) begin
      $display("** quaternion_vector_rotate: PASSED **");
    end else begin
      $display("** quaternion_vector_rotate: FAILED **");
    end
    $finish;
  end

endmodule
